### src/bpt_pkg.sv
// Shared types, constants and helpers for the blink pattern timer.
// No dependencies; every other file in src but bpt_res_if refers to this package by scoped names.
package bpt_pkg;

	localparam int TIME_WIDTH = 16;
	localparam int PERIOD_WIDTH = 16;
	localparam int CMP_WIDTH = (TIME_WIDTH > PERIOD_WIDTH) ? TIME_WIDTH : PERIOD_WIDTH;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_SET   = 2'd1,
		CMD_START = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic                    level;
		logic [PERIOD_WIDTH-1:0] on_time;
		logic [PERIOD_WIDTH-1:0] off_time;
		logic [PERIOD_WIDTH-1:0] repeat_count;
	} cmd_item_t;

	typedef struct packed {
		logic pin_on;
		logic busy_res;
		logic blinking;
	} res_item_t;

	// saturate a period to the range of the elapsed counter
	function automatic logic [TIME_WIDTH-1:0] clip_time(input logic [PERIOD_WIDTH-1:0] t);
		logic [CMP_WIDTH-1:0] wide;
		wide = CMP_WIDTH'(t);
		if (wide > CMP_WIDTH'(TIME_MAX)) begin
			return TIME_MAX;
		end else begin
			return TIME_WIDTH'(wide);
		end
	endfunction

endpackage

### src/bpt_cmd_if.sv
// Command channel: valid/ready handshake carrying one tick or command item.
// Depends on bpt_pkg for the period width.
interface bpt_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       cmd;
	logic                             level;
	logic [bpt_pkg::PERIOD_WIDTH-1:0] on_time;
	logic [bpt_pkg::PERIOD_WIDTH-1:0] off_time;
	logic [bpt_pkg::PERIOD_WIDTH-1:0] repeat_count;

	modport source (output valid, cmd, level, on_time, off_time, repeat_count, input ready);
	modport sink (input valid, cmd, level, on_time, off_time, repeat_count, output ready);
endinterface

### src/bpt_res_if.sv
// Result channel: valid/ready handshake carrying the pin and status flags.
// No package dependency.
interface bpt_res_if;
	logic valid;
	logic ready;
	logic pin_on;
	logic busy_res;
	logic blinking;

	modport source (output valid, pin_on, busy_res, blinking, input ready);
	modport sink (input valid, pin_on, busy_res, blinking, output ready);
endinterface

### src/bpt_in_stage.sv
// Input register stage: captures one command item per cycle from the command channel while no staged item is blocked.
// Depends on bpt_pkg and bpt_cmd_if.
module bpt_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	bpt_cmd_if.sink            cmd_ch,
	input  logic               advance,
	output logic               valid_s1,
	output bpt_pkg::cmd_item_t item_s1
);

	logic load;

	assign cmd_ch.ready = !valid_s1 || advance;
	assign load = cmd_ch.valid && cmd_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.cmd          <= bpt_pkg::cmd_t'(cmd_ch.cmd);
			item_s1.level        <= cmd_ch.level;
			item_s1.on_time      <= cmd_ch.on_time;
			item_s1.off_time     <= cmd_ch.off_time;
			item_s1.repeat_count <= cmd_ch.repeat_count;
		end
	end

endmodule

### src/bpt_core.sv
// Blink state and its per-item update: tick timing, steady level, start and stop.
// Depends on bpt_pkg; produces the result for the item it applies.
module bpt_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  bpt_pkg::cmd_item_t   item_s1,
	output bpt_pkg::res_item_t   res_next
);

	logic                               pin_q, pin_d;
	logic                               wanted_q, wanted_d;
	logic                               active_q, active_d;
	logic                               cont_q, cont_d;
	logic [bpt_pkg::PERIOD_WIDTH-1:0]   reps_q, reps_d;
	logic [bpt_pkg::TIME_WIDTH-1:0]     elapsed_q, elapsed_d;
	logic [bpt_pkg::PERIOD_WIDTH-1:0]   on_q, on_d;
	logic [bpt_pkg::PERIOD_WIDTH-1:0]   off_q, off_d;

	logic [bpt_pkg::TIME_WIDTH-1:0]     elapsed_inc;
	logic [bpt_pkg::TIME_WIDTH-1:0]     limit;
	logic [bpt_pkg::PERIOD_WIDTH-1:0]   reps_dec;
	logic                               still_active;

	always_comb begin
		elapsed_inc = (elapsed_q != bpt_pkg::TIME_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		limit = bpt_pkg::clip_time(wanted_q ? off_q : on_q);
		reps_dec = (reps_q != '0) ? reps_q - 1'b1 : reps_q;
		still_active = cont_q || (reps_dec != '0);
	end

	always_comb begin
		pin_d     = pin_q;
		wanted_d  = wanted_q;
		active_d  = active_q;
		cont_d    = cont_q;
		reps_d    = reps_q;
		elapsed_d = elapsed_q;
		on_d      = on_q;
		off_d     = off_q;
		case (item_s1.cmd)
			bpt_pkg::CMD_TICK: begin
				elapsed_d = elapsed_inc;
				if (active_q) begin
					if ((cont_q || reps_q != '0) && elapsed_inc >= limit) begin
						pin_d = wanted_q;
						elapsed_d = '0;
						if (!wanted_q) begin
							// low edge uses up one repeat
							reps_d = reps_dec;
							if (!still_active) begin
								active_d = 1'b0;
							end else begin
								wanted_d = 1'b1;
							end
						end else begin
							wanted_d = 1'b0;
						end
					end
				end else begin
					pin_d = wanted_q;
				end
			end
			bpt_pkg::CMD_SET: begin
				wanted_d  = item_s1.level;
				active_d  = 1'b0;
				elapsed_d = '0;
			end
			bpt_pkg::CMD_START: begin
				wanted_d  = 1'b1;
				active_d  = 1'b1;
				on_d      = item_s1.on_time;
				off_d     = item_s1.off_time;
				reps_d    = item_s1.repeat_count;
				cont_d    = (item_s1.repeat_count == '0);
				// preload so the first tick drives the pin high
				elapsed_d = bpt_pkg::clip_time(item_s1.off_time);
			end
			bpt_pkg::CMD_STOP: begin
				wanted_d = 1'b0;
				active_d = 1'b0;
				cont_d   = 1'b0;
			end
			default: begin
				pin_d = pin_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q     <= 1'b0;
			wanted_q  <= 1'b0;
			active_q  <= 1'b0;
			cont_q    <= 1'b0;
			reps_q    <= '0;
			elapsed_q <= '0;
			on_q      <= '0;
			off_q     <= '0;
		end else if (advance) begin
			pin_q     <= pin_d;
			wanted_q  <= wanted_d;
			active_q  <= active_d;
			cont_q    <= cont_d;
			reps_q    <= reps_d;
			elapsed_q <= elapsed_d;
			on_q      <= on_d;
			off_q     <= off_d;
		end
	end

	assign res_next.pin_on   = pin_d;
	assign res_next.busy_res = (reps_d != '0);
	assign res_next.blinking = active_d;

endmodule

### src/bpt_out_stage.sv
// Result register: holds one result item until the result channel takes it.
// Depends on bpt_pkg and bpt_res_if.
module bpt_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  bpt_pkg::res_item_t res_next,
	output logic               advance,
	bpt_res_if.source          res_ch
);

	logic               valid_q;
	bpt_pkg::res_item_t res_q;

	// move the staged item on when the result slot is free or being emptied
	assign advance = valid_s1 && (!valid_q || res_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || res_ch.ready) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign res_ch.valid    = valid_q;
	assign res_ch.pin_on   = res_q.pin_on;
	assign res_ch.busy_res = res_q.busy_res;
	assign res_ch.blinking = res_q.blinking;

endmodule

### src/blink_pattern_timer_top.sv
// Blink pattern timer: one result item per accepted tick or command item.
// Path from acceptance to result valid: input register, then result register.
// Throughput: one item per cycle while the result channel does not stall.
// Reset: arst_n clears the pin, blink state, counters and both stage valids; pin starts low.
// Depends on bpt_pkg, bpt_cmd_if, bpt_res_if, bpt_in_stage, bpt_core and bpt_out_stage.
module blink_pattern_timer_top (
	input  logic      clk,
	input  logic      arst_n,
	bpt_cmd_if.sink   cmd_ch,
	bpt_res_if.source res_ch
);

	logic               valid_s1;
	logic               advance;
	bpt_pkg::cmd_item_t item_s1;
	bpt_pkg::res_item_t res_next;

	bpt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_ch   (cmd_ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bpt_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item_s1  (item_s1),
		.res_next (res_next)
	);

	bpt_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res_next (res_next),
		.advance  (advance),
		.res_ch   (res_ch)
	);

	a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ch.ready |-> (valid_s1 && !advance))
		else $error("command channel stalled without a blocked staged item");

	a_staged_item_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_ch.valid)
		else $error("applied item produced no result");

	a_stop_ends_blink: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == bpt_pkg::CMD_STOP) |=> !res_ch.blinking)
		else $error("stop left blink active");

	a_start_loads_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == bpt_pkg::CMD_START && item_s1.repeat_count != '0)
		|=> (res_ch.busy_res && res_ch.blinking))
		else $error("start with repeats did not show busy blinking");

endmodule

### bench/tb.sv
// Self-checking bench for blink_pattern_timer_top: drives tick and command items,
// predicts pin and status flags per item, and checks every result item in order.
// Depends on bpt_pkg, bpt_cmd_if, bpt_res_if and the RTL under src.
module tb;
	import bpt_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int QUIET_TAIL = 150;
	localparam int PRESSURE_AT = 300;
	localparam int PRESSURE_LEN = 150;

	logic clk;
	logic arst_n;

	bpt_cmd_if cmd_ch ();
	bpt_res_if res_ch ();

	blink_pattern_timer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	// predicted block state, all clear after reset
	logic                    pin_q = 1'b0;
	logic                    want_q = 1'b0;
	logic                    blink_q = 1'b0;
	logic                    cont_q = 1'b0;
	logic [PERIOD_WIDTH-1:0] reps_q = '0;
	logic [PERIOD_WIDTH-1:0] on_q = '0;
	logic [PERIOD_WIDTH-1:0] off_q = '0;
	logic [TIME_WIDTH-1:0]   elapsed_q = '0;

	cmd_item_t pending_cmds[$];
	res_item_t expected_flags[$];

	int  total_cmds = 0;
	int  quiet_from = 0;
	int  sent_count = 0;
	int  cmds_taken = 0;
	int  results_seen = 0;
	int  blink_starts = 0;
	int  errors = 0;
	int  stall_cycles = 0;
	int  send_gap = 0;
	int  take_gap = 0;
	int  drain_hold = 0;
	bit  pressure_done = 1'b0;
	bit  timed_out = 1'b0;
	logic cmd_fire = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [TIME_WIDTH-1:0] period_limit(logic [PERIOD_WIDTH-1:0] p);
		if (64'(p) > 64'(TIME_MAX)) begin
			return TIME_MAX;
		end
		return TIME_WIDTH'(p);
	endfunction

	// apply one item to the predicted state and return the flags it leaves behind
	function automatic res_item_t blink_apply(cmd_item_t it);
		res_item_t r;
		case (it.cmd)
			CMD_TICK: begin
				if (elapsed_q != TIME_MAX) begin
					elapsed_q = elapsed_q + 1'b1;
				end
				if (blink_q) begin
					if ((cont_q || reps_q != 0) &&
					    elapsed_q >= period_limit(want_q ? off_q : on_q)) begin
						pin_q = want_q;
						elapsed_q = '0;
						// falling edge uses up one repeat
						if (!want_q) begin
							if (reps_q != 0) begin
								reps_q = reps_q - 1'b1;
							end
							if (!cont_q && reps_q == 0) begin
								blink_q = 1'b0;
							end
						end
						if (blink_q) begin
							want_q = ~want_q;
						end
					end
				end else begin
					pin_q = want_q;
				end
			end
			CMD_SET: begin
				want_q = it.level;
				blink_q = 1'b0;
				elapsed_q = '0;
			end
			CMD_START: begin
				want_q = 1'b1;
				blink_q = 1'b1;
				on_q = it.on_time;
				off_q = it.off_time;
				reps_q = it.repeat_count;
				cont_q = (it.repeat_count == 0);
				elapsed_q = period_limit(it.off_time);
			end
			default: begin
				want_q = 1'b0;
				blink_q = 1'b0;
				cont_q = 1'b0;
			end
		endcase
		r.pin_on = pin_q;
		r.busy_res = (reps_q != 0);
		r.blinking = blink_q;
		return r;
	endfunction

	function automatic void queue_cmd(cmd_t c, logic lvl, logic [PERIOD_WIDTH-1:0] t_on,
		logic [PERIOD_WIDTH-1:0] t_off, logic [PERIOD_WIDTH-1:0] reps);
		cmd_item_t it;
		it.cmd = c;
		it.level = lvl;
		it.on_time = t_on;
		it.off_time = t_off;
		it.repeat_count = reps;
		pending_cmds.push_back(it);
		if (c == CMD_START) begin
			blink_starts++;
		end
	endfunction

	// ticks ignore everything but cmd, so fill the rest with noise half the time
	function automatic void queue_tick();
		if ($urandom_range(0, 1)) begin
			queue_cmd(CMD_TICK, 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		end
	endfunction

	// command driver: change inputs on the falling edge only
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid = 1'b0;
		end else if (cmd_ch.valid && !cmd_fire) begin
			// hold the offered item until it is taken
		end else if (send_gap > 0) begin
			cmd_ch.valid = 1'b0;
			send_gap--;
		end else if (pending_cmds.size() == 0) begin
			cmd_ch.valid = 1'b0;
		end else if (sent_count < quiet_from && (sent_count / 128) % 4 != 3 &&
		             $urandom_range(0, 9) == 0) begin
			cmd_ch.valid = 1'b0;
			send_gap = $urandom_range(0, 6);
		end else begin
			cmd_ch.cmd = pending_cmds[0].cmd;
			cmd_ch.level = pending_cmds[0].level;
			cmd_ch.on_time = pending_cmds[0].on_time;
			cmd_ch.off_time = pending_cmds[0].off_time;
			cmd_ch.repeat_count = pending_cmds[0].repeat_count;
			cmd_ch.valid = 1'b1;
			void'(pending_cmds.pop_front());
			sent_count++;
		end
	end

	// result receiver: random stalls plus one long hold so the input side backs up
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready = 1'b0;
		end else if (drain_hold > 0) begin
			res_ch.ready = 1'b0;
			drain_hold--;
		end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
			res_ch.ready = 1'b0;
			drain_hold = PRESSURE_LEN - 1;
			pressure_done = 1'b1;
		end else if (take_gap > 0) begin
			res_ch.ready = 1'b0;
			take_gap--;
		end else if (results_seen < quiet_from && (results_seen / 128) % 4 != 1 &&
		             $urandom_range(0, 9) == 0) begin
			res_ch.ready = 1'b0;
			take_gap = $urandom_range(0, 6);
		end else begin
			res_ch.ready = 1'b1;
		end
	end

	// monitor: predict on each accepted command item, check each accepted result item
	always @(posedge clk) begin
		cmd_item_t it;
		res_item_t want;
		if (arst_n) begin
			cmd_fire <= cmd_ch.valid && cmd_ch.ready;
			if (cmd_ch.valid && cmd_ch.ready) begin
				it.cmd = cmd_t'(cmd_ch.cmd);
				it.level = cmd_ch.level;
				it.on_time = cmd_ch.on_time;
				it.off_time = cmd_ch.off_time;
				it.repeat_count = cmd_ch.repeat_count;
				expected_flags.push_back(blink_apply(it));
				cmds_taken++;
			end
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (expected_flags.size() == 0) begin
					$error("result item with nothing expected");
					errors++;
				end else begin
					want = expected_flags.pop_front();
					if (res_ch.pin_on !== want.pin_on) begin
						$error("pin_on: expected %0b, got %0b", want.pin_on, res_ch.pin_on);
						errors++;
					end
					if (res_ch.busy_res !== want.busy_res) begin
						$error("busy_res: expected %0b, got %0b", want.busy_res,
							res_ch.busy_res);
						errors++;
					end
					if (res_ch.blinking !== want.blinking) begin
						$error("blinking: expected %0b, got %0b", want.blinking,
							res_ch.blinking);
						errors++;
					end
				end
			end
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int kind;
		int n;
		logic [PERIOD_WIDTH-1:0] t_on;
		logic [PERIOD_WIDTH-1:0] t_off;

		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = CMD_TICK;
		cmd_ch.level = 1'b0;
		cmd_ch.on_time = '0;
		cmd_ch.off_time = '0;
		cmd_ch.repeat_count = '0;
		res_ch.ready = 1'b0;

		// directed: steady levels, zero and full periods, saturation, continuous mode
		queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		queue_cmd(CMD_SET, 1'b1, '0, '0, '0);
		queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		queue_cmd(CMD_SET, 1'b0, '1, '1, '1);
		queue_cmd(CMD_TICK, 1'b1, '1, '1, '1);
		queue_cmd(CMD_START, 1'b0, '0, '0, 16'd1);
		queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		// full off time saturates the elapsed counter, first tick still goes high
		queue_cmd(CMD_START, 1'b1, '1, '1, '1);
		queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		// stop keeps the repeat count, so busy stays up
		queue_cmd(CMD_STOP, 1'b0, '0, '0, '0);
		queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		queue_cmd(CMD_SET, 1'b1, '0, '0, '0);
		queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		// start with the pin already high, continuous
		queue_cmd(CMD_START, 1'b0, 16'd1, 16'd2, '0);
		repeat (4) queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		queue_cmd(CMD_SET, 1'b1, '0, '0, '0);
		queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
		queue_cmd(CMD_STOP, 1'b1, '1, '1, '1);
		queue_cmd(CMD_TICK, 1'b1, '1, '1, '1);
		queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);

		// random: mostly start-then-tick sequences, some noise and steady levels
		while (pending_cmds.size() < 1450) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				t_on = PERIOD_WIDTH'($urandom_range(0, 6));
				t_off = PERIOD_WIDTH'($urandom_range(0, 6));
				if ($urandom_range(0, 15) == 0) begin
					t_on = PERIOD_WIDTH'($urandom);
				end
				if ($urandom_range(0, 15) == 0) begin
					t_off = PERIOD_WIDTH'($urandom);
				end
				queue_cmd(CMD_START, 1'($urandom), t_on, t_off,
					PERIOD_WIDTH'($urandom_range(0, 4)));
				n = $urandom_range(4, 40);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 39))
						0: queue_cmd(CMD_STOP, 1'($urandom), 16'($urandom), 16'($urandom),
							16'($urandom));
						1: queue_cmd(CMD_SET, 1'($urandom), 16'($urandom), 16'($urandom),
							16'($urandom));
						default: queue_tick();
					endcase
				end
			end else if (kind <= 8) begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++) begin
					queue_cmd(cmd_t'(2'($urandom_range(0, 3))), 1'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom));
				end
			end else begin
				queue_cmd(CMD_SET, 1'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
				repeat ($urandom_range(1, 4)) queue_tick();
			end
		end
		total_cmds = pending_cmds.size();
		quiet_from = total_cmds - QUIET_TAIL;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		while (!timed_out && !(pending_cmds.size() == 0 && cmds_taken == total_cmds &&
		                       expected_flags.size() == 0)) begin
			@(posedge clk);
			if (stall_cycles >= STALL_LIMIT) begin
				timed_out = 1'b1;
			end
		end
		if (!timed_out) begin
			repeat (10) @(posedge clk);
		end

		$display("Drove %0d items (%0d blink starts), checked %0d result items.",
			cmds_taken, blink_starts, results_seen);
		$display("Mismatches: %0d, timeout: %0d.", errors, timed_out);
		if (errors == 0 && !timed_out) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
